[rtl/trsp_pkg.sv]
`timescale 1ns / 1ps

package trsp_pkg;

    // Input item modes.
    localparam logic [2:0] MODE_START  = 3'd0;
    localparam logic [2:0] MODE_TARGET = 3'd1;
    localparam logic [2:0] MODE_SETPOS = 3'd2;
    localparam logic [2:0] MODE_STOP   = 3'd3;
    localparam logic [2:0] MODE_RAMP   = 3'd4;
    localparam logic [2:0] MODE_PULSE  = 3'd5;

    // Configuration register indexes.
    localparam logic [1:0] CFG_MIN_FREQ = 2'd0;
    localparam logic [1:0] CFG_MAX_FREQ = 2'd1;
    localparam logic [1:0] CFG_RAMP_UP  = 2'd2;
    localparam logic [1:0] CFG_RAMP_DN  = 2'd3;

    // Prescaler codes.
    localparam logic [2:0] PSC_DIV1    = 3'd0;
    localparam logic [2:0] PSC_DIV8    = 3'd1;
    localparam logic [2:0] PSC_DIV64   = 3'd2;
    localparam logic [2:0] PSC_DIV256  = 3'd3;
    localparam logic [2:0] PSC_DIV1024 = 3'd4;

    // Widths of the serial arithmetic units.
    localparam int MulAW   = 33;
    localparam int MulBW   = 25;
    localparam int ProdW   = MulAW + MulBW;
    localparam int DivDW   = ProdW;
    localparam int DivVW   = 25;

    localparam logic [19:0] FREQ_LIMIT = 20'hFFFFF;
    localparam logic [23:0] CLOCK_HZ   = 24'd16000000;

    typedef enum logic [3:0] {
        S_IDLE,
        S_APPLY,
        S_CLASS,
        S_SMUL_A,
        S_SMUL_B,
        S_TMUL,
        S_TDIV,
        S_CV,
        S_CDIV,
        S_DONE
    } t_state;

    // Outcome of the ramp classification.
    typedef enum logic [2:0] {
        PICK_MIN,
        PICK_MAX,
        PICK_UP,
        PICK_DN,
        PICK_SHORT
    } t_pick;

    typedef enum logic [1:0] {
        MS_SHORT_A,
        MS_SHORT_B,
        MS_TERM_UP,
        MS_TERM_DN
    } t_mul_sel;

    typedef enum logic {
        DS_TERM,
        DS_CMP
    } t_div_sel;

    typedef enum logic [1:0] {
        FS_MIN,
        FS_MAX,
        FS_TERM
    } t_freq_sel;

    typedef struct packed {
        logic      load_in;
        logic      apply;
        logic      mul_start;
        t_mul_sel  mul_sel;
        logic      save_p1;
        logic      div_start;
        t_div_sel  div_sel;
        logic      freq_load;
        t_freq_sel freq_sel;
        logic      out_load;
    } t_dp_cmd;

    typedef struct packed {
        logic [2:0] mode;
        logic       ramp_ok;
        t_pick      pick;
        logic       short_up;
        logic       mul_done;
        logic       div_done;
        logic       freq_zero;
        logic       out_free;
    } t_dp_stat;

    // Prescaler code for a frequency.
    function automatic logic [2:0] psc_code(input logic [19:0] f);
        logic [2:0] c;
        if (f >= 20'd250) c = PSC_DIV1;
        else if (f >= 20'd50) c = PSC_DIV8;
        else if (f >= 20'd2) c = PSC_DIV64;
        else if (f >= 20'd1) c = PSC_DIV256;
        else c = PSC_DIV1024;
        return c;
    endfunction

    // Left shift that gives 2 * divider.
    function automatic logic [3:0] psc_shift(input logic [2:0] c);
        logic [3:0] s;
        case (c)
            PSC_DIV1:   s = 4'd1;
            PSC_DIV8:   s = 4'd4;
            PSC_DIV64:  s = 4'd7;
            PSC_DIV256: s = 4'd9;
            default:    s = 4'd11;
        endcase
        return s;
    endfunction

endpackage

[rtl/trsp_mul.sv]
`timescale 1ns / 1ps

module trsp_mul (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_start,
    input  logic [trsp_pkg::MulAW-1:0]  i_a,
    input  logic [trsp_pkg::MulBW-1:0]  i_b,
    output logic [trsp_pkg::ProdW-1:0]  o_prod,
    output logic                        o_done
);
    import trsp_pkg::*;

    localparam int CntW = $clog2(MulBW + 1);

    logic [ProdW-1:0] r_acc;
    logic [ProdW-1:0] r_a;
    logic [MulBW-1:0] r_b;
    logic [CntW-1:0]  r_cnt;
    logic             r_busy;
    logic             r_done;

    // Control: one multiplier bit per cycle.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == CntW'(MulBW - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // Shift-and-add datapath.
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_acc <= '0;
            r_a   <= ProdW'(i_a);
            r_b   <= i_b;
        end else if (r_busy) begin
            if (r_b[0]) begin
                r_acc <= r_acc + r_a;
            end
            r_a <= {r_a[ProdW-2:0], 1'b0};
            r_b <= {1'b0, r_b[MulBW-1:1]};
        end
    end

    assign o_prod = r_acc;
    assign o_done = r_done;
endmodule

[rtl/trsp_div.sv]
`timescale 1ns / 1ps

module trsp_div (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_start,
    input  logic [trsp_pkg::DivDW-1:0]  i_dividend,
    input  logic [trsp_pkg::DivVW-1:0]  i_divisor,
    output logic [trsp_pkg::DivDW-1:0]  o_quot,
    output logic                        o_done
);
    import trsp_pkg::*;

    localparam int CntW = $clog2(DivDW + 1);

    logic [DivDW-1:0] r_quo;
    logic [DivVW-1:0] r_rem;
    logic [DivVW-1:0] r_dsr;
    logic [CntW-1:0]  r_cnt;
    logic             r_busy;
    logic             r_done;
    logic [DivVW:0]   rem_sh;
    logic             fits;

    // Restoring step: shift one dividend bit into the remainder.
    assign rem_sh = {r_rem, r_quo[DivDW-1]};
    assign fits   = (rem_sh >= {1'b0, r_dsr});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == CntW'(DivDW - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_quo <= i_dividend;
            r_rem <= '0;
            r_dsr <= i_divisor;
        end else if (r_busy) begin
            r_quo <= {r_quo[DivDW-2:0], fits};
            if (fits) begin
                r_rem <= DivVW'(rem_sh - {1'b0, r_dsr});
            end else begin
                r_rem <= rem_sh[DivVW-1:0];
            end
        end
    end

    assign o_quot = r_quo;
    assign o_done = r_done;
endmodule

[rtl/trsp_dp.sv]
`timescale 1ns / 1ps

module trsp_dp (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_cfg_we,
    input  logic [1:0]          i_cfg_idx,
    input  logic [23:0]         i_cfg_wdata,
    input  logic [39:0]         i_s_axis_tdata,
    input  logic                i_m_axis_tready,
    output logic                o_m_axis_tvalid,
    output logic [79:0]         o_m_axis_tdata,
    input  trsp_pkg::t_dp_cmd   i_cmd,
    output trsp_pkg::t_dp_stat  o_stat
);
    import trsp_pkg::*;

    // Configuration registers.
    logic [19:0] r_min_freq, r_max_freq;
    logic [23:0] r_ramp_up, r_ramp_dn;

    // Motion state.
    logic [31:0] r_pos, r_target, r_start;
    logic        r_fwd, r_run, r_level;
    logic [19:0] r_freq;

    // Latched input item.
    logic [2:0]  r_mode;
    logic [31:0] r_value;
    logic        r_dir;

    // Ramp working registers.
    logic [32:0]      r_dist, r_moved;
    logic [ProdW-1:0] r_p1;
    logic             r_use_up;

    // Result register.
    logic        r_out_valid;
    logic [79:0] r_out_data;

    logic [32:0] n_dist, n_moved, rem;
    logic [32:0] d_tgt, d_pos;
    logic        n_level;
    logic [31:0] n_pos;
    logic [19:0] span;
    logic [24:0] up_dn;
    t_pick       pick;

    logic [MulAW-1:0] mul_a;
    logic [MulBW-1:0] mul_b;
    logic [ProdW-1:0] mul_prod;
    logic             mul_done;
    logic [DivDW-1:0] div_dvd;
    logic [DivVW-1:0] div_dsr;
    logic [DivDW-1:0] div_quot;
    logic             div_done;

    logic [23:0] len;
    logic [20:0] f_sum;
    logic [19:0] f_term;
    logic [2:0]  code;
    logic [15:0] cmp;

    // Configuration writes.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_min_freq <= 20'd10000;
            r_max_freq <= 20'd50000;
            r_ramp_up  <= 24'd5000;
            r_ramp_dn  <= 24'd5000;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_MIN_FREQ: r_min_freq <= i_cfg_wdata[19:0];
                CFG_MAX_FREQ: r_max_freq <= i_cfg_wdata[19:0];
                CFG_RAMP_UP:  r_ramp_up  <= i_cfg_wdata;
                CFG_RAMP_DN:  r_ramp_dn  <= i_cfg_wdata;
            endcase
        end
    end

    // Exact distances from the move start, as 33-bit magnitudes.
    always_comb begin
        d_tgt   = {r_target[31], r_target} - {r_start[31], r_start};
        d_pos   = {r_pos[31], r_pos} - {r_start[31], r_start};
        n_dist  = d_tgt[32] ? (~d_tgt + 33'd1) : d_tgt;
        n_moved = d_pos[32] ? (~d_pos + 33'd1) : d_pos;
    end

    // Pulse edge: toggle, count on the falling edge.
    always_comb begin
        n_level = ~r_level;
        if (n_level) begin
            n_pos = r_pos;
        end else if (r_fwd) begin
            n_pos = r_pos + 32'd1;
        end else begin
            n_pos = r_pos - 32'd1;
        end
    end

    // Item latch and command execution.
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_in) begin
            r_mode  <= i_s_axis_tdata[2:0];
            r_value <= i_s_axis_tdata[34:3];
            r_dir   <= i_s_axis_tdata[35];
        end
        if (i_cmd.apply) begin
            r_dist  <= n_dist;
            r_moved <= n_moved;
        end
        if (i_cmd.save_p1) begin
            r_p1 <= mul_prod;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos    <= '0;
            r_target <= '0;
            r_start  <= '0;
            r_fwd    <= 1'b1;
            r_run    <= 1'b0;
            r_level  <= 1'b0;
            r_freq   <= '0;
        end else begin
            if (i_cmd.apply) begin
                case (r_mode)
                    MODE_START: begin
                        r_target <= r_value;
                        r_start  <= r_pos;
                        r_fwd    <= r_dir;
                        r_run    <= 1'b1;
                        r_freq   <= (r_max_freq > r_min_freq) ? r_min_freq : r_max_freq;
                    end
                    MODE_TARGET: r_target <= r_value;
                    MODE_SETPOS: r_pos    <= r_value;
                    MODE_STOP:   r_run    <= 1'b0;
                    MODE_PULSE: begin
                        if (r_run) begin
                            r_level <= n_level;
                            r_pos   <= n_pos;
                            if (r_fwd) begin
                                r_run <= !($signed(n_pos) >= $signed(r_target));
                            end else begin
                                r_run <= !($signed(n_pos) <= $signed(r_target));
                            end
                        end
                    end
                    default: ;
                endcase
            end
            if (i_cmd.freq_load) begin
                unique case (i_cmd.freq_sel)
                    FS_MIN:  r_freq <= r_min_freq;
                    FS_MAX:  r_freq <= r_max_freq;
                    FS_TERM: r_freq <= f_sum[20] ? FREQ_LIMIT : f_sum[19:0];
                    default: r_freq <= r_freq;
                endcase
            end
        end
    end

    // Ramp classification.
    always_comb begin
        rem   = (r_moved >= r_dist) ? 33'd0 : (r_dist - r_moved);
        span  = r_max_freq - r_min_freq;
        up_dn = {1'b0, r_ramp_up} + {1'b0, r_ramp_dn};
        if (r_dist >= {8'd0, up_dn}) begin
            if (r_moved == 33'd0 || rem == 33'd0) pick = PICK_MIN;
            else if (r_moved < {9'd0, r_ramp_up}) pick = PICK_UP;
            else if (rem < {9'd0, r_ramp_dn}) pick = PICK_DN;
            else pick = PICK_MAX;
        end else begin
            pick = PICK_SHORT;
        end
    end

    // Multiplier operands.
    always_comb begin
        unique case (i_cmd.mul_sel)
            MS_SHORT_A: begin mul_a = r_moved; mul_b = up_dn; end
            MS_SHORT_B: begin mul_a = r_dist;  mul_b = {1'b0, r_ramp_up}; end
            MS_TERM_UP: begin mul_a = r_moved; mul_b = {5'd0, span}; end
            default:    begin mul_a = rem;     mul_b = {5'd0, span}; end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.mul_start) begin
            r_use_up <= (i_cmd.mul_sel == MS_TERM_UP);
        end
    end

    trsp_mul u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_cmd.mul_start),
        .i_a     (mul_a),
        .i_b     (mul_b),
        .o_prod  (mul_prod),
        .o_done  (mul_done)
    );

    // Divider operands: ramp term or timer compare value.
    assign len  = r_use_up ? r_ramp_up : r_ramp_dn;
    assign code = psc_code(r_freq);

    always_comb begin
        if (i_cmd.div_sel == DS_TERM) begin
            div_dvd = mul_prod;
            div_dsr = {1'b0, len};
        end else begin
            div_dvd = DivDW'(CLOCK_HZ);
            div_dsr = DivVW'({5'd0, r_freq} << psc_shift(code));
        end
    end

    trsp_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_cmd.div_start),
        .i_dividend (div_dvd),
        .i_divisor  (div_dsr),
        .o_quot     (div_quot),
        .o_done     (div_done)
    );

    // Ramp frequency with saturation; a zero ramp length gives no term.
    always_comb begin
        if (len == 24'd0) begin
            f_term = '0;
            f_sum  = {1'b0, r_min_freq};
        end else if (div_quot[DivDW-1:20] != '0) begin
            f_term = FREQ_LIMIT;
            f_sum  = {1'b1, FREQ_LIMIT};
        end else begin
            f_term = div_quot[19:0];
            f_sum  = {1'b0, r_min_freq} + {1'b0, f_term};
        end
    end

    assign cmp = (r_freq == 20'd0) ? 16'hFFFF : div_quot[15:0];

    // Result register; it takes the next result once the current one is taken.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_out_valid <= 1'b1;
        end else if (i_m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_out_data <= {7'd0, r_level, r_run, r_pos, cmp, code, r_freq};
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = r_out_data;

    always_comb begin
        o_stat.mode      = r_mode;
        o_stat.ramp_ok   = r_run && (r_max_freq > r_min_freq);
        o_stat.pick      = pick;
        o_stat.short_up  = (r_p1 < mul_prod);
        o_stat.mul_done  = mul_done;
        o_stat.div_done  = div_done;
        o_stat.freq_zero = (r_freq == 20'd0);
        o_stat.out_free  = !r_out_valid || i_m_axis_tready;
    end
endmodule

[rtl/trsp_ctrl.sv]
`timescale 1ns / 1ps

module trsp_ctrl (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_s_axis_tvalid,
    output logic                o_s_axis_tready,
    input  trsp_pkg::t_dp_stat  i_stat,
    output trsp_pkg::t_dp_cmd   o_cmd
);
    import trsp_pkg::*;

    t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE:   if (i_s_axis_tvalid) n_state = S_APPLY;
            S_APPLY: begin
                if (i_stat.mode == MODE_RAMP && i_stat.ramp_ok) n_state = S_CLASS;
                else n_state = S_CV;
            end
            S_CLASS: begin
                unique case (i_stat.pick)
                    PICK_SHORT:     n_state = S_SMUL_A;
                    PICK_UP, PICK_DN: n_state = S_TMUL;
                    default:        n_state = S_CV;
                endcase
            end
            S_SMUL_A: if (i_stat.mul_done) n_state = S_SMUL_B;
            S_SMUL_B: if (i_stat.mul_done) n_state = S_TMUL;
            S_TMUL:   if (i_stat.mul_done) n_state = S_TDIV;
            S_TDIV:   if (i_stat.div_done) n_state = S_CV;
            S_CV:     n_state = i_stat.freq_zero ? S_DONE : S_CDIV;
            S_CDIV:   if (i_stat.div_done) n_state = S_DONE;
            S_DONE:   if (i_stat.out_free) n_state = S_IDLE;
            default:  n_state = S_IDLE;
        endcase
    end

    // Commands to the datapath.
    always_comb begin
        o_cmd = '0;
        o_cmd.mul_sel  = MS_SHORT_A;
        o_cmd.div_sel  = DS_TERM;
        o_cmd.freq_sel = FS_MIN;
        o_s_axis_tready = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                // The input stays closed while reset is held.
                o_s_axis_tready = i_rst_n;
                o_cmd.load_in   = i_s_axis_tvalid;
            end
            S_APPLY: o_cmd.apply = 1'b1;
            S_CLASS: begin
                unique case (i_stat.pick)
                    PICK_SHORT: begin
                        o_cmd.mul_start = 1'b1;
                        o_cmd.mul_sel   = MS_SHORT_A;
                    end
                    PICK_UP: begin
                        o_cmd.mul_start = 1'b1;
                        o_cmd.mul_sel   = MS_TERM_UP;
                    end
                    PICK_DN: begin
                        o_cmd.mul_start = 1'b1;
                        o_cmd.mul_sel   = MS_TERM_DN;
                    end
                    PICK_MAX: begin
                        o_cmd.freq_load = 1'b1;
                        o_cmd.freq_sel  = FS_MAX;
                    end
                    default: begin
                        o_cmd.freq_load = 1'b1;
                        o_cmd.freq_sel  = FS_MIN;
                    end
                endcase
            end
            S_SMUL_A: begin
                if (i_stat.mul_done) begin
                    o_cmd.save_p1   = 1'b1;
                    o_cmd.mul_start = 1'b1;
                    o_cmd.mul_sel   = MS_SHORT_B;
                end
            end
            S_SMUL_B: begin
                if (i_stat.mul_done) begin
                    o_cmd.mul_start = 1'b1;
                    o_cmd.mul_sel   = i_stat.short_up ? MS_TERM_UP : MS_TERM_DN;
                end
            end
            S_TMUL: begin
                if (i_stat.mul_done) begin
                    o_cmd.div_start = 1'b1;
                    o_cmd.div_sel   = DS_TERM;
                end
            end
            S_TDIV: begin
                if (i_stat.div_done) begin
                    o_cmd.freq_load = 1'b1;
                    o_cmd.freq_sel  = FS_TERM;
                end
            end
            S_CV: begin
                if (!i_stat.freq_zero) begin
                    o_cmd.div_start = 1'b1;
                    o_cmd.div_sel   = DS_CMP;
                end
            end
            S_CDIV: ;
            S_DONE: o_cmd.out_load = i_stat.out_free;
            default: ;
        endcase
    end
endmodule

[rtl/trapezoid_ramp_step_pulse_generator.sv]
`timescale 1ns / 1ps
// Commands and pulse edges give their result once the 58-step serial divider has formed the
// timer compare value; when the frequency is zero no divide is needed.
// Ramp ticks take up to three 25-step multiplies and two divides.
// Throughput: one item at a time; the next is accepted once the result is registered.
// Reset (synchronous, active low) restores the default ramp settings and clears the motion state.
module trapezoid_ramp_step_pulse_generator (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // Configuration write port.
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_idx,
    input  logic [23:0] i_cfg_wdata,
    // Input items.
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    // mode[2:0], value[34:3], direction[35], zero fill
    input  logic [39:0] i_s_axis_tdata,
    // Results.
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    // step_freq[19:0], prescale_code[22:20], compare_value[38:23],
    // position[70:39], running[71], step_level[72], zero fill
    output logic [79:0] o_m_axis_tdata
);
    import trsp_pkg::*;

    t_dp_cmd  cmd;
    t_dp_stat stat;

    trsp_ctrl u_ctrl (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_stat          (stat),
        .o_cmd           (cmd)
    );

    trsp_dp u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_idx       (i_cfg_idx),
        .i_cfg_wdata     (i_cfg_wdata),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .i_cmd           (cmd),
        .o_stat          (stat)
    );

    // An accepted transaction keeps the input side closed in the next cycle.
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_s_axis_tvalid && o_s_axis_tready) |=> !o_s_axis_tready)
        else $error("input accepted while an item is in progress");

    // A result is only loaded when the result register can take it.
    a_load_when_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.out_load |-> stat.out_free)
        else $error("result register overwritten");

    // The multiplier and the divider are never started together.
    a_one_unit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(cmd.mul_start && cmd.div_start))
        else $error("multiplier and divider started together");

    // No new item is taken while a result is being loaded.
    a_no_load_on_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.out_load |-> !o_s_axis_tready)
        else $error("accept and result load in the same cycle");
endmodule
